// File: rtl/cfsp_pkg.sv
// Package for the class file stream parser: phase codes, event kinds and
// beat payload structs. No dependencies.
package cfsp_pkg;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_MINOR, PH_MAJOR, PH_PCOUNT, PH_TAG, PH_ULEN, PH_UBYTES, PH_PVAL,
    PH_FLAGS, PH_THIS, PH_SUPER, PH_ICOUNT, PH_IFACE, PH_FCOUNT, PH_MFLAGS,
    PH_MNAME, PH_MDESC, PH_MACOUNT, PH_ANAME, PH_ALEN, PH_ABYTES, PH_MCOUNT,
    PH_CACOUNT, PH_DONE, PH_FAIL
  } phase_e;

  localparam logic [4:0] K_MINOR = 5'd0, K_MAJOR = 5'd1, K_PCOUNT = 5'd2,
    K_ULEN = 5'd3, K_UBYTE = 5'd4, K_CONST4 = 5'd5, K_CONST8 = 5'd6,
    K_IDX1 = 5'd7, K_IDX2 = 5'd8, K_FLAGS = 5'd9, K_THIS = 5'd10,
    K_SUPER = 5'd11, K_ICOUNT = 5'd12, K_IFACE = 5'd13, K_FCOUNT = 5'd14,
    K_MCOUNT = 5'd15, K_CACOUNT = 5'd16, K_MFLAGS = 5'd17, K_MNAME = 5'd18,
    K_MDESC = 5'd19, K_MACOUNT = 5'd20, K_ANAME = 5'd21, K_ALEN = 5'd22,
    K_ABYTE = 5'd23, K_FINISHED = 5'd28, K_FAILED = 5'd29;

  localparam logic [2:0] OW_POOL = 3'd0, OW_CLASS = 3'd1, OW_FIELD = 3'd2,
    OW_METHOD = 3'd3, OW_CATTR = 3'd4;

  localparam logic [1:0] E_NONE = 2'd0, E_MAGIC = 2'd1, E_TAG = 2'd2, E_EMPTY = 2'd3;

  localparam logic [31:0] MAGIC = 32'hCAFEBABE;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  owner;
    logic [7:0]  pool_tag;
    logic [31:0] position;
    logic [63:0] value;
    logic [1:0]  error_code;
  } out_beat_t;

endpackage

// File: rtl/class_file_stream_parser.sv
// Class file stream parser top level: input register, decode step, output register.
// Depends on cfsp_pkg.
//
// One byte per beat; each byte passes the input register, combinational decode
// and the result register, giving at most one event beat. The rate is one byte
// per cycle unless the output stalls, set by word assembly and phase update; a
// stalled output holds in the result register while one more byte is taken.
module class_file_stream_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cfsp_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfsp_pkg::out_beat_t out_data_o
);
  import cfsp_pkg::*;

  // input register
  logic     iv_q;
  in_beat_t ib_q;
  // result register
  logic      ov_q, ov_d;
  out_beat_t ob_q, ob_d;

  phase_e      ph_q, ph_d;
  logic [2:0]  biw_q, biw_d;
  logic [63:0] sh_q, sh_d;
  logic [15:0] slot_q, slot_d, limit_q, limit_d, tleft_q, tleft_d, mnum_q, mnum_d;
  logic [15:0] aleft_q, aleft_d, anum_q, anum_d;
  logic [31:0] pleft_q, pleft_d, poff_q, poff_d;
  logic [7:0]  tag_q, tag_d;
  logic [2:0]  own_q, own_d;

  logic out_free, step;
  assign out_free    = !ov_q || out_ready_i;
  assign step        = iv_q && out_free;
  assign in_ready_o  = !iv_q || out_free;
  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ready_o) begin
      iv_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) ib_q <= in_data_i;
  end

  always_comb begin
    logic [7:0]  b;
    phase_e      p;
    logic [2:0]  cnt, wsz;
    logic [63:0] w;
    logic [31:0] w32;
    logic        fin, emit, wide;
    logic [16:0] nxt;
    logic [4:0]  kind;
    logic [2:0]  owner;
    logic [7:0]  tg;
    logic [31:0] pos;
    b = ib_q.data_byte;
    p = ph_q; biw_d = biw_q; sh_d = sh_q; slot_d = slot_q; limit_d = limit_q;
    tag_d = tag_q; tleft_d = tleft_q; mnum_d = mnum_q; aleft_d = aleft_q;
    anum_d = anum_q; pleft_d = pleft_q; poff_d = poff_q; own_d = own_q;
    if (ib_q.first_byte) begin
      p = PH_MAGIC; biw_d = '0; sh_d = '0; slot_d = '0; limit_d = '0; tag_d = '0;
      tleft_d = '0; mnum_d = '0; aleft_d = '0; anum_d = '0; pleft_d = '0;
      poff_d = '0; own_d = '0;
    end
    ph_d = p;
    fin = 1'b0; emit = 1'b0; kind = '0; owner = OW_CLASS; tg = '0; pos = '0;
    ob_d = '0;
    w = {sh_d[55:0], b};
    w32 = w[31:0];
    wide = (tag_d == 8'd5) || (tag_d == 8'd6);
    nxt = {1'b0, slot_d} + (wide ? 17'd2 : 17'd1);
    unique case (p)
      PH_MAGIC, PH_ALEN: wsz = 3'd4;
      PH_PVAL: wsz = wide ? 3'd0 : ((tag_d == 8'd7 || tag_d == 8'd8) ? 3'd2 : 3'd4);
      default: wsz = 3'd2;
    endcase
    cnt = biw_d + 3'd1;
    unique case (p)
      PH_DONE, PH_FAIL: ;
      PH_TAG: begin
        if (!(b == 8'd1 || (b >= 8'd3 && b <= 8'd12))) begin
          ph_d = PH_FAIL; emit = 1'b1;
          ob_d = '{K_FAILED, OW_POOL, b, {16'd0, slot_d}, {56'd0, b}, E_TAG};
        end else begin
          tag_d = b; ph_d = (b == 8'd1) ? PH_ULEN : PH_PVAL;
        end
      end
      PH_UBYTES: begin
        emit = 1'b1;
        ob_d = '{K_UBYTE, OW_POOL, tag_d, poff_d, {56'd0, b}, E_NONE};
        poff_d = poff_d + 32'd1; pleft_d = pleft_d - 32'd1;
        if (pleft_d == 32'd0) begin
          slot_d = nxt[15:0]; ph_d = (nxt >= {1'b0, limit_d}) ? PH_FLAGS : PH_TAG;
        end
      end
      PH_ABYTES: begin
        emit = 1'b1; pos = poff_d;
        poff_d = poff_d + 32'd1; pleft_d = pleft_d - 32'd1;
        if (pleft_d == 32'd0) begin
          anum_d = anum_d + 16'd1; aleft_d = aleft_d - 16'd1;
          if (aleft_d != 16'd0) ph_d = PH_ANAME;
          else if (own_d == OW_CATTR) begin ph_d = PH_DONE; fin = 1'b1; end
          else begin
            mnum_d = mnum_d + 16'd1; tleft_d = tleft_d - 16'd1;
            ph_d = (tleft_d != 16'd0) ? PH_MFLAGS
                 : ((own_d == OW_FIELD) ? PH_MCOUNT : PH_CACOUNT);
          end
        end
        ob_d = '{fin ? K_FINISHED : K_ABYTE, own_d, 8'd0, pos, {56'd0, b}, E_NONE};
      end
      default: begin
        if (wsz == 3'd0 ? (cnt != 3'd0) : (cnt < wsz)) begin
          biw_d = cnt; sh_d = w;
        end else begin
          biw_d = '0; sh_d = '0; emit = 1'b1;
          priority case (p)
            PH_MAGIC: begin
              if (w32 != MAGIC) begin
                ph_d = PH_FAIL;
                ob_d = '{K_FAILED, OW_CLASS, 8'd0, 32'd0, {32'd0, w32}, E_MAGIC};
              end else begin
                ph_d = PH_MINOR;
              end
            end
            PH_MINOR: begin kind = K_MINOR; ph_d = PH_MAJOR; end
            PH_MAJOR: begin kind = K_MAJOR; ph_d = PH_PCOUNT; end
            PH_PCOUNT: begin
              if (w32 <= 32'd1) begin
                ph_d = PH_FAIL;
                ob_d = '{K_FAILED, OW_CLASS, 8'd0, 32'd0, {32'd0, w32}, E_EMPTY};
              end else begin
                kind = K_PCOUNT; limit_d = w32[15:0]; slot_d = 16'd1; ph_d = PH_TAG;
              end
            end
            PH_ULEN: begin
              kind = K_ULEN; owner = OW_POOL; tg = tag_d; pos = {16'd0, slot_d};
              pleft_d = w32; poff_d = '0;
              if (w32 == 32'd0) begin
                slot_d = nxt[15:0]; ph_d = (nxt >= {1'b0, limit_d}) ? PH_FLAGS : PH_TAG;
              end else ph_d = PH_UBYTES;
            end
            PH_PVAL: begin
              owner = OW_POOL; tg = tag_d; pos = {16'd0, slot_d};
              if (tag_d == 8'd3 || tag_d == 8'd4) kind = K_CONST4;
              else if (wide) kind = K_CONST8;
              else if (tag_d == 8'd7 || tag_d == 8'd8) kind = K_IDX1;
              else kind = K_IDX2;
              slot_d = nxt[15:0]; ph_d = (nxt >= {1'b0, limit_d}) ? PH_FLAGS : PH_TAG;
            end
            PH_FLAGS: begin kind = K_FLAGS; ph_d = PH_THIS; end
            PH_THIS: begin kind = K_THIS; ph_d = PH_SUPER; end
            PH_SUPER: begin kind = K_SUPER; ph_d = PH_ICOUNT; end
            PH_ICOUNT: begin
              kind = K_ICOUNT; tleft_d = w32[15:0]; mnum_d = '0;
              ph_d = (w32 == 32'd0) ? PH_FCOUNT : PH_IFACE;
            end
            PH_IFACE: begin
              kind = K_IFACE; pos = {16'd0, mnum_d};
              mnum_d = mnum_d + 16'd1; tleft_d = tleft_d - 16'd1;
              if (tleft_d == 16'd0) ph_d = PH_FCOUNT;
            end
            PH_FCOUNT, PH_MCOUNT: begin
              kind = (p == PH_FCOUNT) ? K_FCOUNT : K_MCOUNT;
              own_d = (p == PH_FCOUNT) ? OW_FIELD : OW_METHOD;
              tleft_d = w32[15:0]; mnum_d = '0;
              if (w32 == 32'd0) ph_d = (own_d == OW_FIELD) ? PH_MCOUNT : PH_CACOUNT;
              else ph_d = PH_MFLAGS;
            end
            PH_MFLAGS: begin
              kind = K_MFLAGS; owner = own_d; pos = {16'd0, mnum_d}; ph_d = PH_MNAME;
            end
            PH_MNAME: begin
              kind = K_MNAME; owner = own_d; pos = {16'd0, mnum_d}; ph_d = PH_MDESC;
            end
            PH_MDESC: begin
              kind = K_MDESC; owner = own_d; pos = {16'd0, mnum_d}; ph_d = PH_MACOUNT;
            end
            PH_MACOUNT: begin
              kind = K_MACOUNT; owner = own_d; pos = {16'd0, mnum_d};
              aleft_d = w32[15:0]; anum_d = '0;
              if (w32 == 32'd0) begin
                mnum_d = mnum_d + 16'd1; tleft_d = tleft_d - 16'd1;
                ph_d = (tleft_d != 16'd0) ? PH_MFLAGS
                     : ((own_d == OW_FIELD) ? PH_MCOUNT : PH_CACOUNT);
              end else ph_d = PH_ANAME;
            end
            PH_CACOUNT: begin
              kind = K_CACOUNT; own_d = OW_CATTR; aleft_d = w32[15:0]; anum_d = '0;
              if (w32 == 32'd0) begin ph_d = PH_DONE; fin = 1'b1; owner = OW_CATTR; end
              else ph_d = PH_ANAME;
            end
            PH_ANAME: begin
              kind = K_ANAME; owner = own_d; pos = {16'd0, anum_d}; ph_d = PH_ALEN;
            end
            PH_ALEN: begin
              kind = K_ALEN; owner = own_d; pos = {16'd0, anum_d};
              pleft_d = w32; poff_d = '0;
              if (w32 == 32'd0) begin
                anum_d = anum_d + 16'd1; aleft_d = aleft_d - 16'd1;
                if (aleft_d != 16'd0) ph_d = PH_ANAME;
                else if (own_d == OW_CATTR) begin ph_d = PH_DONE; fin = 1'b1; end
                else begin
                  mnum_d = mnum_d + 16'd1; tleft_d = tleft_d - 16'd1;
                  ph_d = (tleft_d != 16'd0) ? PH_MFLAGS
                       : ((own_d == OW_FIELD) ? PH_MCOUNT : PH_CACOUNT);
                end
              end else ph_d = PH_ABYTES;
            end
            default: begin ph_d = PH_FAIL; emit = 1'b0; end
          endcase
          // errors already set their beat; the good magic word gives no beat
          if (p == PH_MAGIC) emit = (w32 != MAGIC);
          else if (!(p == PH_PCOUNT && w32 <= 32'd1))
            ob_d = '{fin ? K_FINISHED : kind, owner, fin ? 8'd0 : tg, pos, w, E_NONE};
        end
      end
    endcase
    ov_d = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_MAGIC; biw_q <= '0; sh_q <= '0; slot_q <= '0; limit_q <= '0;
      tag_q <= '0; tleft_q <= '0; mnum_q <= '0; aleft_q <= '0; anum_q <= '0;
      pleft_q <= '0; poff_q <= '0; own_q <= '0; ov_q <= 1'b0;
    end else begin
      if (step) begin
        ph_q <= ph_d; biw_q <= biw_d; sh_q <= sh_d; slot_q <= slot_d;
        limit_q <= limit_d; tag_q <= tag_d; tleft_q <= tleft_d; mnum_q <= mnum_d;
        aleft_q <= aleft_d; anum_q <= anum_d; pleft_q <= pleft_d; poff_q <= poff_d;
        own_q <= own_d;
      end
      if (out_free) ov_q <= step && ov_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (step && ov_d) ob_q <= ob_d;
  end

endmodule

// File: rtl/cfsp_checker.sv
// Port-level checker for class_file_stream_parser, bound to the top level.
// Depends on cfsp_pkg.
module cfsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cfsp_pkg::out_beat_t out_data_o
);
  import cfsp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // a fresh result beat needs a decode step, which needs a free input side
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_ready_o))
    else $error("result beat without an accepted byte");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result register");

  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != E_NONE |-> out_data_o.kind == K_FAILED)
    else $error("error code on a non-failure beat");
endmodule

bind class_file_stream_parser cfsp_checker u_cfsp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
